// ----- hdl/lut3d_tetrahedral_interp_macros.svh -----
// ----------------------------------------------------------------------------
// lut3d_tetrahedral_interp_macros.svh
// assertion helpers shared by the colour lut rtl
// ----------------------------------------------------------------------------
`ifndef LUT3D_TETRAHEDRAL_INTERP_MACROS_SVH
`define LUT3D_TETRAHEDRAL_INTERP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LT3D_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define LT3D_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/lt3d_pkg.sv -----
// ----------------------------------------------------------------------------
// lt3d_pkg
// types, constants and helpers for the tetrahedral colour lut
// ----------------------------------------------------------------------------
`default_nettype none

package lt3d_pkg;

  // grid points per axis the node store is sized for
  localparam int unsigned MaxDim = 33;

  localparam int unsigned NodeW = 16;
  localparam int unsigned PixW  = 18;
  localparam int unsigned DimW  = 6;
  localparam int unsigned DdW   = 12;
  localparam int unsigned WgtW  = 17;
  localparam int unsigned ProdW = WgtW + NodeW;
  localparam int unsigned AccW  = ProdW + 1;

  localparam logic [WgtW-1:0] OneQ16   = 17'h10000;
  localparam logic [AccW-1:0] RoundQ16 = 34'd32768;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqPixel = 1'b1;

  // one rgb node of the cube
  typedef struct packed {
    logic [NodeW-1:0] red;
    logic [NodeW-1:0] green;
    logic [NodeW-1:0] blue;
  } node_t;

  // accepted request item
  typedef struct packed {
    logic                    req_type;
    logic [15:0]             node_index;
    node_t                   node;
    logic signed [PixW-1:0]  pix_red;
    logic signed [PixW-1:0]  pix_green;
    logic signed [PixW-1:0]  pix_blue;
    logic signed [PixW-1:0]  pix_alpha;
  } req_t;

  // pixel control riding along the pipeline
  typedef struct packed {
    logic                   valid;
    logic signed [PixW-1:0] alpha;
  } pix_ctl_t;

  // node write towards the memories
  typedef struct packed {
    logic  en;
    node_t node;
  } wr_t;

  // signed q2.16 clamped to 0..1.0
  function automatic logic [WgtW-1:0] clamp_unit(logic signed [PixW-1:0] v);
    logic [WgtW-1:0] r;
    if (v[PixW-1]) begin
      r = '0;
    end else if (v[PixW-2:0] > OneQ16) begin
      r = OneQ16;
    end else begin
      r = v[PixW-2:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/lt3d_in_if.sv -----
// ----------------------------------------------------------------------------
// lt3d_in_if
// request channel: node writes and pixels
// ----------------------------------------------------------------------------
`default_nettype none

interface lt3d_in_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [15:0]       node_index;
  logic [15:0]       node_red;
  logic [15:0]       node_green;
  logic [15:0]       node_blue;
  logic signed [17:0] pix_red;
  logic signed [17:0] pix_green;
  logic signed [17:0] pix_blue;
  logic signed [17:0] pix_alpha;

  modport source (
    output valid, req_type, node_index, node_red, node_green, node_blue,
    output pix_red, pix_green, pix_blue, pix_alpha,
    input  ready
  );
  modport sink (
    input  valid, req_type, node_index, node_red, node_green, node_blue,
    input  pix_red, pix_green, pix_blue, pix_alpha,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/lt3d_out_if.sv -----
// ----------------------------------------------------------------------------
// lt3d_out_if
// result channel: interpolated pixels
// ----------------------------------------------------------------------------
`default_nettype none

interface lt3d_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        out_red;
  logic [15:0]        out_green;
  logic [15:0]        out_blue;
  logic signed [17:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/lt3d_cfg_if.sv -----
// ----------------------------------------------------------------------------
// lt3d_cfg_if
// configuration write channel for the lut dimension
// ----------------------------------------------------------------------------
`default_nettype none

interface lt3d_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/lt3d_node_ram.sv -----
// ----------------------------------------------------------------------------
// lt3d_node_ram
// one copy of the node store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lt3d_node_ram #(
  parameter int unsigned DEPTH  = 35937,
  parameter int unsigned ADDR_W = 16
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [ADDR_W-1:0]   wa_i,
  input  wire lt3d_pkg::node_t     wd_i,
  input  wire logic                re_i,
  input  wire logic [ADDR_W-1:0]   ra_i,
  output      lt3d_pkg::node_t     rd_o
);

  lt3d_pkg::node_t mem [DEPTH];
  lt3d_pkg::node_t rd_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
  end

  // read port, data held while stalled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q <= mem[ra_i];
    end
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

// ----- hdl/lt3d_idx.sv -----
// ----------------------------------------------------------------------------
// lt3d_idx
// lattice cell, tetrahedron corners and weights for one item per cycle while adv_i is high
// ----------------------------------------------------------------------------
`default_nettype none

module lt3d_idx #(
  parameter int unsigned DEPTH  = 35937,
  parameter int unsigned ADDR_W = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic                          acc_i,
  input  wire lt3d_pkg::req_t                req_i,
  input  wire logic [lt3d_pkg::DimW-1:0]     dim_i,
  input  wire logic [lt3d_pkg::DdW-1:0]      dd_i,
  output      lt3d_pkg::wr_t                 wr_o,
  output      logic [ADDR_W-1:0]             wa_o,
  output      logic [3:0][ADDR_W-1:0]        corner_o,
  output      logic [3:0][lt3d_pkg::WgtW-1:0] wgt_o,
  output      lt3d_pkg::pix_ctl_t            ctl_o
);

  localparam int unsigned PW = 23;
  localparam int unsigned SW = 18;
  localparam int unsigned DW = lt3d_pkg::DimW;

  // stage 0: item register
  logic            v0_q;
  lt3d_pkg::req_t  r0_q;

  // stage 1: scaled channels
  logic                  pv1_q, wv1_q;
  logic [2:0][PW-1:0]    p1_q;
  logic [15:0]           wa1_q;
  lt3d_pkg::node_t       nd1_q;
  logic signed [17:0]    al1_q;

  // stage 2: corner coordinates and weights
  logic                          pv2_q, wv2_q;
  logic [3:0][2:0][DW-1:0]       cc2_q;
  logic [3:0][lt3d_pkg::WgtW-1:0] w2_q;
  logic [15:0]                   wa2_q;
  lt3d_pkg::node_t               nd2_q;
  logic signed [17:0]            al2_q;

  // stage 3: memory addresses
  logic                          pv3_q, wv3_q;
  logic [3:0][ADDR_W-1:0]        cn3_q;
  logic [3:0][lt3d_pkg::WgtW-1:0] w3_q;
  logic [ADDR_W-1:0]             wa3_q;
  lt3d_pkg::node_t               nd3_q;
  logic signed [17:0]            al3_q;

  logic [DW-1:0]              top;
  logic [2:0][PW-1:0]         p1_d;
  logic [2:0][DW-1:0]         lo, hi;
  logic [2:0][15:0]           fr;
  logic                       gr, gg, gb;
  logic [2:0]                 a_next, b_prev;
  logic [15:0]                x0, x1, x2;
  logic [17:0]                fsum;
  logic [3:0][2:0][DW-1:0]    cc2_d;
  logic [3:0][lt3d_pkg::WgtW-1:0] w2_d;
  logic [3:0][ADDR_W-1:0]     cn3_d;
  logic                       wr_ok;

  assign top = dim_i - DW'(1);

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      pv1_q <= 1'b0;
      wv1_q <= 1'b0;
      pv2_q <= 1'b0;
      wv2_q <= 1'b0;
      pv3_q <= 1'b0;
      wv3_q <= 1'b0;
    end else if (adv_i) begin
      v0_q  <= acc_i;
      pv1_q <= v0_q && (r0_q.req_type == lt3d_pkg::ReqPixel);
      wv1_q <= v0_q && (r0_q.req_type == lt3d_pkg::ReqWrite);
      pv2_q <= pv1_q;
      wv2_q <= wv1_q && wr_ok;
      pv3_q <= pv2_q;
      wv3_q <= wv2_q;
    end
  end

  // clamp and scale by dim-1
  always_comb begin
    p1_d[0] = PW'(lt3d_pkg::clamp_unit(r0_q.pix_red)) * PW'(top);
    p1_d[1] = PW'(lt3d_pkg::clamp_unit(r0_q.pix_green)) * PW'(top);
    p1_d[2] = PW'(lt3d_pkg::clamp_unit(r0_q.pix_blue)) * PW'(top);
  end

  assign wr_ok = 32'(wa1_q) < 32'(DEPTH);

  // cell split, corner choice and sorted weights
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      lo[ch] = p1_q[ch][16+DW-1:16];
      fr[ch] = p1_q[ch][15:0];
      hi[ch] = (lo[ch] >= top) ? top : lo[ch] + DW'(1);
    end
    gr = fr[0] > fr[1];
    gg = fr[1] > fr[2];
    gb = fr[2] > fr[0];
    a_next[0] = !gb && gr;
    a_next[1] = !gr && gg;
    a_next[2] = !gg && gb;
    b_prev[0] = !gr && gb;
    b_prev[1] = !gg && gr;
    b_prev[2] = !gb && gg;
    for (int ch = 0; ch < 3; ch++) begin
      cc2_d[0][ch] = lo[ch];
      cc2_d[1][ch] = a_next[ch] ? hi[ch] : lo[ch];
      cc2_d[2][ch] = b_prev[ch] ? lo[ch] : hi[ch];
      cc2_d[3][ch] = hi[ch];
    end
    x0 = (fr[0] > fr[1]) ? fr[0] : fr[1];
    x0 = (x0 > fr[2]) ? x0 : fr[2];
    x2 = (fr[0] < fr[1]) ? fr[0] : fr[1];
    x2 = (x2 < fr[2]) ? x2 : fr[2];
    fsum = 18'(fr[0]) + 18'(fr[1]) + 18'(fr[2]);
    x1 = 16'(fsum - 18'(x0) - 18'(x2));
    w2_d[0] = lt3d_pkg::OneQ16 - lt3d_pkg::WgtW'(x0);
    w2_d[1] = lt3d_pkg::WgtW'(x0 - x1);
    w2_d[2] = lt3d_pkg::WgtW'(x1 - x2);
    w2_d[3] = lt3d_pkg::WgtW'(x2);
  end

  // node address r*dim*dim + g*dim + b
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cn3_d[k] = ADDR_W'(SW'(cc2_q[k][0]) * SW'(dd_i)
                       + SW'(cc2_q[k][1]) * SW'(dim_i)
                       + SW'(cc2_q[k][2]));
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r0_q  <= req_i;
      p1_q  <= p1_d;
      wa1_q <= r0_q.node_index;
      nd1_q <= r0_q.node;
      al1_q <= r0_q.pix_alpha;
      cc2_q <= cc2_d;
      w2_q  <= w2_d;
      wa2_q <= wa1_q;
      nd2_q <= nd1_q;
      al2_q <= al1_q;
      cn3_q <= cn3_d;
      w3_q  <= w2_q;
      wa3_q <= ADDR_W'(wa2_q);
      nd3_q <= nd2_q;
      al3_q <= al2_q;
    end
  end

  assign wr_o.en    = wv3_q;
  assign wr_o.node  = nd3_q;
  assign wa_o       = wa3_q;
  assign corner_o   = cn3_q;
  assign wgt_o      = w3_q;
  assign ctl_o.valid = pv3_q;
  assign ctl_o.alpha = al3_q;

endmodule

`default_nettype wire

// ----- hdl/lt3d_blend.sv -----
// ----------------------------------------------------------------------------
// lt3d_blend
// weighted sum of the four corner nodes, rounding and output register
// ----------------------------------------------------------------------------
`default_nettype none

module lt3d_blend (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            adv_i,
  input  wire lt3d_pkg::pix_ctl_t              ctl_i,
  input  wire logic [3:0][lt3d_pkg::WgtW-1:0]  wgt_i,
  input  wire lt3d_pkg::node_t [3:0]           node_i,
  output      logic                            valid_o,
  output      logic [2:0][15:0]                rgb_o,
  output      logic signed [17:0]              alpha_o
);

  localparam int unsigned PrW = lt3d_pkg::ProdW;
  localparam int unsigned AcW = lt3d_pkg::AccW;

  lt3d_pkg::pix_ctl_t               c4_q, c5_q;
  logic [3:0][lt3d_pkg::WgtW-1:0]   w4_q;
  logic [3:0][2:0][PrW-1:0]         pr5_q, pr5_d;
  logic                             ov_q;
  logic [2:0][15:0]                 rgb_q, rgb_d;
  logic signed [17:0]               al_q;
  logic [2:0][AcW-1:0]              acc;

  // pixel control: valid bits and alpha
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c4_q <= '0;
      c5_q <= '0;
      ov_q <= 1'b0;
    end else if (adv_i) begin
      c4_q <= ctl_i;
      c5_q <= c4_q;
      ov_q <= c5_q.valid;
    end
  end

  // products of weight and node channel
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pr5_d[k][0] = PrW'(w4_q[k]) * PrW'(node_i[k].red);
      pr5_d[k][1] = PrW'(w4_q[k]) * PrW'(node_i[k].green);
      pr5_d[k][2] = PrW'(w4_q[k]) * PrW'(node_i[k].blue);
    end
  end

  // sum, round half up, saturate
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = lt3d_pkg::RoundQ16 + AcW'(pr5_q[0][ch]) + AcW'(pr5_q[1][ch])
              + AcW'(pr5_q[2][ch]) + AcW'(pr5_q[3][ch]);
      rgb_d[ch] = (acc[ch][AcW-1:32] != '0) ? 16'hFFFF : acc[ch][31:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      w4_q  <= wgt_i;
      pr5_q <= pr5_d;
      rgb_q <= rgb_d;
      al_q  <= c5_q.alpha;
    end
  end

  assign valid_o = ov_q;
  assign rgb_o   = rgb_q;
  assign alpha_o = al_q;

endmodule

`default_nettype wire

// ----- hdl/lut3d_tetrahedral_interp.sv -----
// a pixel passes the item, scaling, corner, address, node read, product and output registers to its result
// throughput: one item per cycle while the output is not stalled, writes and pixels mixed in any order
// the four corner reads use four copies of the node store, one read port each
// a stalled output holds the whole pipeline; nothing is dropped
// reset clears control state and sets lut_dim to 33; node store is not cleared
// ----------------------------------------------------------------------------
// lut3d_tetrahedral_interp
// 3d colour lut with tetrahedral interpolation, pipelined
// ----------------------------------------------------------------------------
`default_nettype none

`include "lut3d_tetrahedral_interp_macros.svh"

module lut3d_tetrahedral_interp (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lt3d_in_if.sink     in_i,
  lt3d_out_if.source  out_o,
  lt3d_cfg_if.sink    cfg_i
);

  localparam int unsigned DEPTH  = lt3d_pkg::MaxDim * lt3d_pkg::MaxDim * lt3d_pkg::MaxDim;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned DW     = lt3d_pkg::DimW;
  localparam logic [DW:0] MaxDim = (DW+1)'(lt3d_pkg::MaxDim);
  localparam logic [DW:0] DimRst = (DW+1)'((lt3d_pkg::MaxDim < 33) ? lt3d_pkg::MaxDim : 33);

  logic                             adv;
  logic                             acc;
  lt3d_pkg::req_t                   req;
  logic [DW-1:0]                    dim_q, dim_d;
  logic [lt3d_pkg::DdW-1:0]         dd_q;
  lt3d_pkg::wr_t                    wr;
  logic [ADDR_W-1:0]                wa;
  logic [3:0][ADDR_W-1:0]           corner;
  logic [3:0][lt3d_pkg::WgtW-1:0]   wgt;
  lt3d_pkg::pix_ctl_t               ctl;
  lt3d_pkg::node_t [3:0]            rd;
  logic [2:0][15:0]                 rgb;

  // pipeline advances unless a result waits
  assign adv         = !out_o.valid || out_o.ready;
  assign in_i.ready  = adv;
  assign acc         = in_i.valid && adv;
  assign cfg_i.ready = 1'b1;

  // request item
  assign req.req_type   = in_i.req_type;
  assign req.node_index = in_i.node_index;
  assign req.node.red   = in_i.node_red;
  assign req.node.green = in_i.node_green;
  assign req.node.blue  = in_i.node_blue;
  assign req.pix_red    = in_i.pix_red;
  assign req.pix_green  = in_i.pix_green;
  assign req.pix_blue   = in_i.pix_blue;
  assign req.pix_alpha  = in_i.pix_alpha;

  // dimension register, held within 2..MAX_DIM
  always_comb begin
    priority if (cfg_i.data < DW'(2)) begin
      dim_d = DW'(2);
    end else if ({1'b0, cfg_i.data} > MaxDim) begin
      dim_d = DW'(MaxDim);
    end else begin
      dim_d = cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DW'(DimRst);
      dd_q  <= lt3d_pkg::DdW'(DimRst) * lt3d_pkg::DdW'(DimRst);
    end else if (cfg_i.valid) begin
      dim_q <= dim_d;
      dd_q  <= lt3d_pkg::DdW'(dim_d) * lt3d_pkg::DdW'(dim_d);
    end
  end

  lt3d_idx #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_idx (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .acc_i    (acc),
    .req_i    (req),
    .dim_i    (dim_q),
    .dd_i     (dd_q),
    .wr_o     (wr),
    .wa_o     (wa),
    .corner_o (corner),
    .wgt_o    (wgt),
    .ctl_o    (ctl)
  );

  // one store copy per tetrahedron corner
  for (genvar k = 0; k < 4; k++) begin : g_bank
    lt3d_node_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
    ) u_ram (
      .clk_i (clk_i),
      .we_i  (wr.en && adv),
      .wa_i  (wa),
      .wd_i  (wr.node),
      .re_i  (adv),
      .ra_i  (corner[k]),
      .rd_o  (rd[k])
    );
  end

  lt3d_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .ctl_i   (ctl),
    .wgt_i   (wgt),
    .node_i  (rd),
    .valid_o (out_o.valid),
    .rgb_o   (rgb),
    .alpha_o (out_o.out_alpha)
  );

  assign out_o.out_red   = rgb[0];
  assign out_o.out_green = rgb[1];
  assign out_o.out_blue  = rgb[2];

  // checks
  `LT3D_ASSERT_IMP(dim_in_range, clk_i, rst_ni, 1'b1, (dim_q >= DW'(2)) && ({1'b0, dim_q} <= MaxDim), "lut_dim out of range")
  `LT3D_ASSERT_IMP(dd_matches_dim, clk_i, rst_ni, 1'b1, dd_q == lt3d_pkg::DdW'(dim_q) * lt3d_pkg::DdW'(dim_q), "dim squared out of step")
  `LT3D_ASSERT_IMP(ready_needs_room, clk_i, rst_ni, in_i.ready, !out_o.valid || out_o.ready, "input taken while result blocked")
  `LT3D_ASSERT_NXT(cfg_in_range_kept, clk_i, rst_ni, cfg_i.valid && cfg_i.data >= DW'(2) && {1'b0, cfg_i.data} <= MaxDim, dim_q == $past(cfg_i.data), "lut_dim write lost")

endmodule

`default_nettype wire
